### rtl/lbo_pkg.sv
// lbo_pkg: shared constants, payload types and window types for the
// outer label boundary finder. No dependencies; lbo_window, lbo_judge and the top level import it.
package lbo_pkg;

  // frame and label limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int LABEL_BITS = 16;

  // register width of frame_width / frame_height, also used for effective sizes
  localparam int DIM_BITS   = 11;
  // column counter indexes the row stores
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  // row counter runs past the last row while draining
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT + 2);
  // one row store word holds the older and the newer label of a column
  localparam int STORE_BITS = 2 * LABEL_BITS;

  // configuration register indexes
  localparam int REG_INDEX_BITS = 1;
  localparam logic [REG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = REG_INDEX_BITS'(0);
  localparam logic [REG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = REG_INDEX_BITS'(1);

  localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET  = DIM_BITS'(1024);
  localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET = DIM_BITS'(1024);

  // request type codes
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] label;
  } item_t;

  typedef struct packed {
    logic boundary;
    logic last;
  } result_t;

  typedef logic [LABEL_BITS-1:0] label_t;

  // 3x3 window, indexed [column][row]; column 0 oldest, row 0 top
  typedef label_t [2:0][2:0] win_t;

  // edge replacement flags and frame end mark for one evaluation
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic last;
  } edges_t;

endpackage

### rtl/lbo_ram.sv
// lbo_ram: generic simple dual port memory, one write and one read port,
// registered read data. No dependencies.
module lbo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/lbo_window.sv
// lbo_window: raster position counters, row store and 3x3 window shift.
// Each step (an accepted transaction other than an early drain) shifts the
// window and may post one evaluation job. Depends on lbo_pkg and lbo_ram.
module lbo_window (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic [lbo_pkg::DIM_BITS-1:0]  width,
  input  logic [lbo_pkg::DIM_BITS-1:0]  height,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  lbo_pkg::item_t                item,
  input  logic                          job_take,
  output logic                          job_valid,
  output lbo_pkg::edges_t               edges,
  output lbo_pkg::win_t                 win
);
  import lbo_pkg::*;

  logic [COL_BITS-1:0]   col, col_next;
  logic [ROW_BITS-1:0]   row, row_next;
  logic [COL_BITS:0]     col_inc;
  logic [ROW_BITS:0]     row_x, h_x, h_plus;
  logic                  pix_phase, accept, step, pixel;
  label_t                lab, top, mid;
  logic                  job_set;
  edges_t                edges_next;

  logic                  ram_we;
  logic [STORE_BITS-1:0] ram_wdata, ram_rdata, rd_word;
  logic                  fwd_hit;
  logic [STORE_BITS-1:0] fwd_data;

  // handshake: hold the input while an evaluation cannot move on
  assign item_stall = job_valid && !job_take;
  assign accept     = item_valid && !item_stall;

  // frame phase: pixels until the last row, drain steps after it
  assign row_x     = {1'b0, row};
  assign h_x       = (ROW_BITS + 1)'(height);
  assign h_plus    = h_x + (ROW_BITS + 1)'(1);
  assign pix_phase = row_x < h_x;
  assign pixel     = pix_phase;
  // a drain request before the frame is complete is dropped
  assign step      = accept && !(pix_phase && item.req_type == REQ_DRAIN);
  assign lab       = pixel ? item.label[LABEL_BITS-1:0] : '0;
  assign col_inc   = {1'b0, col} + (COL_BITS + 1)'(1);

  // next position and evaluation job for this transaction
  always_comb begin
    col_next   = col;
    row_next   = row;
    job_set    = 1'b0;
    edges_next = '0;
    if (restart) begin
      col_next = '0;
      row_next = '0;
    end else if (step) begin
      if (DIM_BITS'(col_inc) >= width) begin
        col_next = '0;
        row_next = ROW_BITS'(row + ROW_BITS'(1));
      end else begin
        col_next = col_inc[COL_BITS-1:0];
      end
      if (col == '0 && row >= ROW_BITS'(2)) begin
        // row start: judge the last column of the row two back
        job_set           = 1'b1;
        edges_next.top    = (row == ROW_BITS'(2));
        edges_next.bottom = (row_x > h_x);
        edges_next.left   = (width == DIM_BITS'(1));
        edges_next.right  = 1'b1;
        edges_next.last   = (row_x == h_plus);
        if (edges_next.last) begin
          col_next = '0;
          row_next = '0;
        end
      end else if (col != '0 && row >= ROW_BITS'(1)) begin
        // judge the previous column of the previous row
        job_set           = 1'b1;
        edges_next.top    = (row == ROW_BITS'(1));
        edges_next.bottom = (row_x >= h_x);
        edges_next.left   = (col == COL_BITS'(1));
        edges_next.right  = 1'b0;
        edges_next.last   = 1'b0;
      end
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

  // row store: read ahead at the next column, bypass a same-column write
  assign ram_we    = step && pixel;
  assign ram_wdata = {mid, lab};

  lbo_ram #(
    .WIDTH(STORE_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_row_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(col),
    .wdata(ram_wdata),
    .raddr(col_next),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= ram_we && (col == col_next);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= ram_wdata;
  end

  assign rd_word = fwd_hit ? fwd_data : ram_rdata;
  assign top     = rd_word[STORE_BITS-1:LABEL_BITS];
  assign mid     = rd_word[LABEL_BITS-1:0];

  // window shift, new column enters on the right
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (step) begin
      win[0]    <= win[1];
      win[1]    <= win[2];
      win[2][0] <= top;
      win[2][1] <= mid;
      win[2][2] <= lab;
    end
  end

  // pending evaluation job
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (step) begin
      job_valid <= job_set;
    end else if (job_take) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && job_set) begin
      edges <= edges_next;
    end
  end

  // column position always inside the row
  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    DIM_BITS'(col) < width)
    else $error("column count reached the frame width");

  // row position never passes the drain row
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    row_x <= h_plus)
    else $error("row count beyond drain row");

  // the frame end result restarts the raster position
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    step && job_set && edges_next.last |=> col == '0 && row == '0)
    else $error("position not cleared after frame end");

endmodule

### rtl/lbo_judge.sv
// lbo_judge: edge replacement on the 3x3 window, outer boundary test and
// the result register. Depends on lbo_pkg.
module lbo_judge (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  lbo_pkg::edges_t  edges,
  input  lbo_pkg::win_t    win,
  output logic             job_take,
  output logic             result_valid,
  input  logic             result_stall,
  output lbo_pkg::result_t result
);
  import lbo_pkg::*;

  logic   load_ok;
  win_t   v;
  label_t center;
  logic   edge4, adj, bg, boundary;
  logic [1:0] csel [3];
  logic [1:0] rsel [3];

  // result register frees when empty or taken
  assign load_ok  = !result_valid || !result_stall;
  assign job_take = job_valid && load_ok;

  // repeat the edge pixel where the neighbor lies outside the frame
  always_comb begin
    csel[0] = edges.left   ? 2'd1 : 2'd0;
    csel[1] = 2'd1;
    csel[2] = edges.right  ? 2'd1 : 2'd2;
    rsel[0] = edges.top    ? 2'd1 : 2'd0;
    rsel[1] = 2'd1;
    rsel[2] = edges.bottom ? 2'd1 : 2'd2;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        v[j][i] = win[csel[j]][rsel[i]];
      end
    end
  end

  // 4-neighbor max != min means some cross neighbor differs from center;
  // 8-neighbor max != min-ignoring-zeros means some nonzero neighbor differs
  always_comb begin
    center = v[1][1];
    bg     = (center == '0);
    edge4  = (v[0][1] != center) || (v[2][1] != center) ||
             (v[1][0] != center) || (v[1][2] != center);
    adj    = 1'b0;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        if (!(j == 1 && i == 1)) begin
          adj = adj || ((v[j][i] != '0) && (v[j][i] != center));
        end
      end
    end
    boundary = edge4 && (bg || adj);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_ok) begin
      result_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      result.boundary <= boundary;
      result.last     <= edges.last;
    end
  end

  // a job waits only behind a stalled result
  a_job_waits_on_stall: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_take |-> result_valid && result_stall)
    else $error("evaluation job held without a stalled result");

  // a stalled result stays put
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // a taken result with nothing behind it empties the register
  a_result_drains: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !job_valid |=> !result_valid)
    else $error("result register did not empty");

endmodule

### rtl/label_boundary_outer_unit.sv
// label_boundary_outer_unit: top level of the outer label boundary finder.
// Holds the frame size registers. Depends on lbo_pkg, lbo_window, lbo_judge.
//
// Usage:
//   item channel (item_valid / item_stall / item): one label pixel per
//   transaction in raster order, req_type pixel; after the frame, drain
//   transactions (W+1 of them) push out the remaining results.
//   result channel (result_valid / result_stall / result): one boundary
//   bit per pixel in raster order, last set on the final pixel's result.
//   Configuration: wr_en / wr_index / wr_data write frame_width or
//   frame_height and restart the frame; write only while the block is idle.
// Order: the transaction that completes a pixel's 3x3 neighborhood, W+1
//   transactions after its own, posts a job; the judge then loads the result register.
// Throughput: one transaction per cycle while item_stall is low, set by the single window shift and
//   one row store read and write per cycle.
// Reset: frame size returns to 1024 x 1024, position to the frame start,
//   window to zero, both channels empty. The row store is not cleared.
// Stall: result_stall holds the result register; a pending evaluation then
//   raises item_stall in the same cycle, so no transaction is lost.
module label_boundary_outer_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  lbo_pkg::item_t                     item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output lbo_pkg::result_t                   result,
  input  logic                               wr_en,
  input  logic [lbo_pkg::REG_INDEX_BITS-1:0] wr_index,
  input  logic [lbo_pkg::DIM_BITS-1:0]       wr_data
);
  import lbo_pkg::*;

  logic [DIM_BITS-1:0] frame_width, frame_height;
  logic [DIM_BITS-1:0] eff_width, eff_height;
  logic                job_valid, job_take;
  edges_t              edges;
  win_t                win;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FRAME_WIDTH:  frame_width  <= wr_data;
        REG_FRAME_HEIGHT: frame_height <= wr_data;
      endcase
    end
  end

  // zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (frame_width == '0) begin
      eff_width = DIM_BITS'(1);
    end else if (frame_width > DIM_BITS'(MAX_WIDTH)) begin
      eff_width = DIM_BITS'(MAX_WIDTH);
    end else begin
      eff_width = frame_width;
    end
    if (frame_height == '0) begin
      eff_height = DIM_BITS'(1);
    end else if (frame_height > DIM_BITS'(MAX_HEIGHT)) begin
      eff_height = DIM_BITS'(MAX_HEIGHT);
    end else begin
      eff_height = frame_height;
    end
  end

  // position, row store and window
  lbo_window u_window (
    .clk       (clk),
    .rst       (rst),
    .restart   (wr_en),
    .width     (eff_width),
    .height    (eff_height),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .job_take  (job_take),
    .job_valid (job_valid),
    .edges     (edges),
    .win       (win)
  );

  // boundary test and result register
  lbo_judge u_judge (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .edges       (edges),
    .win         (win),
    .job_take    (job_take),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule
